[rtl/core/jsu_pkg.sv]
// Shared types and constants for the JSON string unescaper.
// Holds the job record passed from the decoder to the result serializer.
// No dependencies.
package jsu_pkg;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  localparam logic [3:0] ERR_NO_QUOTE     = 4'd0;
  localparam logic [3:0] ERR_UNTERMINATED = 4'd1;
  localparam logic [3:0] ERR_CONTROL      = 4'd2;
  localparam logic [3:0] ERR_TRUNC_ESC    = 4'd3;
  localparam logic [3:0] ERR_UNKNOWN_ESC  = 4'd4;
  localparam logic [3:0] ERR_TRUNC_HEX    = 4'd5;
  localparam logic [3:0] ERR_BAD_HEX      = 4'd6;
  localparam logic [3:0] ERR_LONE_SURR    = 4'd7;
  localparam logic [3:0] ERR_BAD_PAIR     = 4'd8;
  localparam logic [3:0] ERR_NUL          = 4'd9;
  localparam logic [3:0] ERR_LAST         = ERR_NUL;

  typedef struct packed {
    kind_t           kind;
    logic [2:0]      cnt;
    logic [3:0][7:0] bytes;
    logic [3:0]      err;
  } job_t;

endpackage

[rtl/core/jsu_front.sv]
// Decoder front end: accepts input bytes, tracks the string state and
// builds one job per input item that yields results. Uses jsu_pkg.
module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          in_command,
  input  logic [7:0]    in_byte,
  output logic          push,
  output jsu_pkg::job_t push_job
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_BODY  = 7'b0000010,
    PH_ESC   = 7'b0000100,
    PH_HEX1  = 7'b0001000,
    PH_HI_BS = 7'b0010000,
    PH_HI_U  = 7'b0100000,
    PH_HEX2  = 7'b1000000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hc_r, hc_nxt;
  logic [15:0] cu_r, cu_nxt;
  logic [9:0]  hp_r, hp_nxt;

  logic [4:0]  hexd;
  logic [15:0] cu_shift;
  logic [20:0] cp_pair;
  logic        clr;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
    return 5'd0;
  endfunction

  function automatic job_t err_job(input logic [3:0] code);
    job_t j;
    j = '0;
    j.kind = KIND_ERROR;
    j.cnt  = 3'd1;
    j.err  = code;
    return j;
  endfunction

  function automatic job_t byte_job(input logic [7:0] b);
    job_t j;
    j = '0;
    j.kind     = KIND_BYTE;
    j.cnt      = 3'd1;
    j.bytes[0] = b;
    return j;
  endfunction

  function automatic job_t utf8_job(input logic [20:0] cp);
    job_t j;
    j = '0;
    j.kind = KIND_BYTE;
    if (cp < 21'h80) begin
      j.cnt      = 3'd1;
      j.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      j.cnt      = 3'd2;
      j.bytes[0] = {3'b110, cp[10:6]};
      j.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      j.cnt      = 3'd3;
      j.bytes[0] = {4'b1110, cp[15:12]};
      j.bytes[1] = {2'b10, cp[11:6]};
      j.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      j.cnt      = 3'd4;
      j.bytes[0] = {5'b11110, cp[20:18]};
      j.bytes[1] = {2'b10, cp[17:12]};
      j.bytes[2] = {2'b10, cp[11:6]};
      j.bytes[3] = {2'b10, cp[5:0]};
    end
    return j;
  endfunction

  assign hexd     = hex_decode(in_byte);
  assign cu_shift = {cu_r[11:0], hexd[3:0]};
  assign cp_pair  = 21'h10000 + 21'({hp_r, cu_shift[9:0]});

  always_comb begin
    phase_nxt = phase_r;
    hc_nxt    = hc_r;
    cu_nxt    = cu_r;
    hp_nxt    = hp_r;
    push      = 1'b0;
    push_job  = '0;
    clr       = 1'b0;
    if (in_fire) begin
      if (in_command) begin
        unique case (phase_r)
          PH_BODY: begin
            push = 1'b1; push_job = err_job(ERR_UNTERMINATED); clr = 1'b1;
          end
          PH_ESC: begin
            push = 1'b1; push_job = err_job(ERR_TRUNC_ESC); clr = 1'b1;
          end
          PH_HEX1: begin
            push = 1'b1; push_job = err_job(ERR_TRUNC_HEX); clr = 1'b1;
          end
          PH_HI_BS, PH_HI_U, PH_HEX2: begin
            push = 1'b1; push_job = err_job(ERR_LONE_SURR); clr = 1'b1;
          end
          default: clr = 1'b1;
        endcase
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            if (in_byte == CH_QUOTE) begin
              phase_nxt = PH_BODY;
            end else begin
              push = 1'b1; push_job = err_job(ERR_NO_QUOTE); clr = 1'b1;
            end
          end
          PH_BODY: begin
            priority if (in_byte == CH_QUOTE) begin
              push = 1'b1; push_job = '0; push_job.kind = KIND_DONE;
              push_job.cnt = 3'd1; clr = 1'b1;
            end else if (in_byte < CH_SPACE) begin
              push = 1'b1; push_job = err_job(ERR_CONTROL); clr = 1'b1;
            end else if (in_byte == CH_BSL) begin
              phase_nxt = PH_ESC;
            end else begin
              push = 1'b1; push_job = byte_job(in_byte);
            end
          end
          PH_ESC: begin
            phase_nxt = PH_BODY;
            push      = 1'b1;
            unique case (in_byte)
              CH_QUOTE: push_job = byte_job(CH_QUOTE);
              CH_BSL:   push_job = byte_job(CH_BSL);
              CH_SLASH: push_job = byte_job(CH_SLASH);
              CH_B:     push_job = byte_job(8'h08);
              CH_F:     push_job = byte_job(8'h0C);
              CH_N:     push_job = byte_job(8'h0A);
              CH_R:     push_job = byte_job(8'h0D);
              CH_T:     push_job = byte_job(8'h09);
              CH_U: begin
                push = 1'b0; phase_nxt = PH_HEX1; hc_nxt = 2'd0; cu_nxt = '0;
              end
              default: begin
                push_job = err_job(ERR_UNKNOWN_ESC); clr = 1'b1;
              end
            endcase
          end
          PH_HEX1, PH_HEX2: begin
            if (!hexd[4]) begin
              push = 1'b1; push_job = err_job(ERR_BAD_HEX); clr = 1'b1;
            end else begin
              cu_nxt = cu_shift;
              if (hc_r != 2'd3) begin
                hc_nxt = hc_r + 2'd1;
              end else begin
                hc_nxt = 2'd0;
                if (phase_r == PH_HEX2) begin
                  if (cu_shift < 16'hDC00 || cu_shift > 16'hDFFF) begin
                    push = 1'b1; push_job = err_job(ERR_BAD_PAIR); clr = 1'b1;
                  end else begin
                    push = 1'b1; push_job = utf8_job(cp_pair);
                    phase_nxt = PH_BODY; cu_nxt = '0; hp_nxt = '0;
                  end
                end else begin
                  priority if (cu_shift >= 16'hD800 && cu_shift <= 16'hDBFF) begin
                    hp_nxt = cu_shift[9:0]; cu_nxt = '0; phase_nxt = PH_HI_BS;
                  end else if (cu_shift >= 16'hDC00 && cu_shift <= 16'hDFFF) begin
                    push = 1'b1; push_job = err_job(ERR_LONE_SURR); clr = 1'b1;
                  end else if (cu_shift == 16'h0000) begin
                    push = 1'b1; push_job = err_job(ERR_NUL); clr = 1'b1;
                  end else begin
                    push = 1'b1; push_job = utf8_job(21'(cu_shift));
                    phase_nxt = PH_BODY; cu_nxt = '0; hp_nxt = '0;
                  end
                end
              end
            end
          end
          PH_HI_BS: begin
            if (in_byte != CH_BSL) begin
              push = 1'b1; push_job = err_job(ERR_LONE_SURR); clr = 1'b1;
            end else begin
              phase_nxt = PH_HI_U;
            end
          end
          PH_HI_U: begin
            if (in_byte != CH_U) begin
              push = 1'b1; push_job = err_job(ERR_LONE_SURR); clr = 1'b1;
            end else begin
              phase_nxt = PH_HEX2; hc_nxt = 2'd0; cu_nxt = '0;
            end
          end
          default: clr = 1'b1;
        endcase
      end
      if (clr) begin
        phase_nxt = PH_IDLE;
        hc_nxt    = 2'd0;
        cu_nxt    = '0;
        hp_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hc_r    <= 2'd0;
      cu_r    <= '0;
      hp_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
      cu_r    <= cu_nxt;
      hp_r    <= hp_nxt;
    end
  end

endmodule

[rtl/core/jsu_queue.sv]
// Job queue between the decoder and the result serializer.
// Small register file with read and write pointers. Uses jsu_pkg.
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::job_t push_job,
  input  logic          pop,
  output jsu_pkg::job_t head_job,
  output logic          full,
  output logic          empty
);
  import jsu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          q_mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/core/jsu_back.sv]
// Result serializer: walks the head job and presents one result per
// transfer on the output channel. Uses jsu_pkg.
module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  jsu_pkg::job_t head_job,
  input  logic          empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_kind,
  output logic [7:0]    out_byte,
  output logic [3:0]    out_error_code,
  output logic          out_last_of_run
);
  import jsu_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       fire;

  assign out_valid       = !empty;
  assign fire            = out_valid && out_ready;
  assign out_kind        = head_job.kind;
  assign out_byte        = (head_job.kind == KIND_BYTE) ? head_job.bytes[idx_r] : 8'd0;
  assign out_error_code  = (head_job.kind == KIND_ERROR) ? head_job.err : 4'd0;
  assign out_last_of_run = ({1'b0, idx_r} == head_job.cnt - 3'd1);
  assign pop             = fire && out_last_of_run;

  always_comb begin
    idx_nxt = idx_r;
    if (fire) begin
      idx_nxt = out_last_of_run ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

[rtl/core/json_string_unescape_top.sv]
// Top level of the JSON string unescaper.
// Connects jsu_front, jsu_queue and jsu_back; uses jsu_pkg.
//
// Input channel (in_valid/in_ready): one item per transfer, either a raw
// string byte (in_command = 0) or an end-of-line marker (in_command = 1).
// Output channel (out_valid/out_ready): one result per transfer, a decoded
// UTF-8 byte, a completion mark or an error code; out_last_of_run flags the
// final result caused by one input item.
// Throughput: one input item per cycle while the job queue has room; the
// output side sends one result per cycle while out_ready is high, up to
// four results per item for a \u escape that encodes to four UTF-8 bytes.
// Each job is written into the job queue register on its input transfer
// and is presented on the output side from there.
// The queue holds QUEUE_DEPTH jobs; in_ready drops only when it is full,
// so a stalled receiver backs up the input after that many jobs.
// Reset: the decoder returns to waiting for an opening quote and the
// queue is emptied; no results are pending.
module json_string_unescape_top #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [3:0] out_error_code,
  output logic       out_last_of_run
);
  import jsu_pkg::*;

  logic in_fire;
  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t push_job;
  job_t head_job;

  assign in_ready = !full;
  assign in_fire  = in_valid && in_ready;

  jsu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_command (in_command),
    .in_byte    (in_byte),
    .push       (push),
    .push_job   (push_job)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (full),
    .empty    (empty)
  );

  jsu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_job        (head_job),
    .empty           (empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_error_code  (out_error_code),
    .out_last_of_run (out_last_of_run)
  );

  a_non_byte_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_BYTE |-> out_last_of_run)
    else $error("completion or error result not last of run");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid)
    else $error("multi-byte run broken by empty queue");

  a_err_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERROR |-> out_error_code <= ERR_LAST && out_byte == 8'd0)
    else $error("bad error result");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job pushed into full queue");

endmodule
